// ----- rtl/csg_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package csg_pkg;

    // Span position inside one rasterization step.
    typedef enum logic [1:0] {
        SEL_0,
        SEL_1,
        SEL_2,
        SEL_3
    } span_sel_t;

    // Occupancy flags of the step queue, seen by both sides.
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

`default_nettype wire

// ----- rtl/csg_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none

module csg_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    input  wire logic             pop,
    output logic      [WIDTH-1:0] head_data,
    output csg_pkg::q_status_t    status
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg;
    logic [PW-1:0]    rd_ptr_next;
    logic [NW-1:0]    count_reg;
    logic [NW-1:0]    count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign head_data    = mem_reg[rd_ptr_reg];
    assign status.full  = (count_reg == NW'(DEPTH));
    assign status.empty = (count_reg == '0);

endmodule

`default_nettype wire

// ----- rtl/csg_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module csg_front #(
    parameter int COORD_BITS  = 12,
    parameter int RADIUS_BITS = 10,
    localparam int OW = RADIUS_BITS + 2,
    localparam int RW = 2 * COORD_BITS + 2 * OW + 1
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic                   mode,
    input  wire logic [COORD_BITS-1:0]  circle_x,
    input  wire logic [COORD_BITS-1:0]  circle_y,
    input  wire logic [RADIUS_BITS-1:0] radius,
    input  wire csg_pkg::q_status_t     q_status,
    output logic                        push,
    output logic [RW-1:0]               push_data
);

    localparam int DW = RADIUS_BITS + 4;

    logic [COORD_BITS-1:0]  cx_reg;
    logic [COORD_BITS-1:0]  cy_reg;
    logic [RADIUS_BITS-1:0] r_reg;
    logic signed [OW-1:0]   ox_reg;
    logic signed [OW-1:0]   ox_next;
    logic signed [OW-1:0]   oy_reg;
    logic signed [OW-1:0]   oy_next;
    logic signed [DW-1:0]   dec_reg;
    logic signed [DW-1:0]   dec_next;
    logic                   active_reg;

    logic                   accept;
    logic signed [DW-1:0]   ox_w;
    logic signed [DW-1:0]   oy_w;
    logic signed [DW-1:0]   r_w;
    logic                   done;

    assign in_stall = q_status.full;
    assign accept   = in_valid && !in_stall;
    assign push     = accept && mode && active_reg;

    assign ox_w = DW'(ox_reg);
    assign oy_w = DW'(oy_reg);
    assign r_w  = signed'({{(DW - RADIUS_BITS){1'b0}}, r_reg});

    // Three-way decision update of the Andres loop.
    always_comb
    begin
        ox_next  = ox_reg;
        oy_next  = oy_reg;
        dec_next = dec_reg;
        if (dec_reg >= (ox_w <<< 1))
        begin
            dec_next = dec_reg - (ox_w <<< 1) - DW'(1);
            ox_next  = ox_reg + OW'(1);
        end
        else if (dec_reg < ((r_w - oy_w) <<< 1))
        begin
            dec_next = dec_reg + (oy_w <<< 1) - DW'(1);
            oy_next  = oy_reg - OW'(1);
        end
        else
        begin
            dec_next = dec_reg + ((oy_w - ox_w - DW'(1)) <<< 1);
            oy_next  = oy_reg - OW'(1);
            ox_next  = ox_reg + OW'(1);
        end
    end

    assign done      = (oy_next < ox_next);
    assign push_data = {cx_reg, cy_reg, ox_reg, oy_reg, done};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cx_reg     <= '0;
            cy_reg     <= '0;
            r_reg      <= '0;
            ox_reg     <= '0;
            oy_reg     <= '0;
            dec_reg    <= '0;
            active_reg <= 1'b0;
        end
        else if (accept)
        begin
            if (!mode)
            begin
                cx_reg     <= circle_x;
                cy_reg     <= circle_y;
                r_reg      <= radius;
                ox_reg     <= '0;
                oy_reg     <= signed'({{(OW - RADIUS_BITS){1'b0}}, radius});
                dec_reg    <= signed'({{(DW - RADIUS_BITS){1'b0}}, radius}) - DW'(1);
                active_reg <= 1'b1;
            end
            else if (active_reg)
            begin
                ox_reg     <= ox_next;
                oy_reg     <= oy_next;
                dec_reg    <= dec_next;
                active_reg <= !done;
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/csg_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module csg_back #(
    parameter int COORD_BITS  = 12,
    parameter int RADIUS_BITS = 10,
    localparam int OW = RADIUS_BITS + 2,
    localparam int RW = 2 * COORD_BITS + 2 * OW + 1,
    localparam int SW = COORD_BITS + 1
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic [RW-1:0]  head_data,
    input  wire csg_pkg::q_status_t q_status,
    output logic                pop,
    output logic                out_valid,
    input  wire logic           out_stall,
    output logic [SW-1:0]       span_y,
    output logic [SW-1:0]       span_x_left,
    output logic [SW-1:0]       span_x_right,
    output logic                last_of_step,
    output logic                circle_done
);

    localparam int WW = ((SW > OW) ? SW : OW) + 1;

    logic [RW-1:0]          rec_reg;
    logic                   rec_valid_reg;
    csg_pkg::span_sel_t     sel_reg;
    csg_pkg::span_sel_t     sel_next;

    logic                   out_valid_reg;
    logic [SW-1:0]          y_reg;
    logic [SW-1:0]          xl_reg;
    logic [SW-1:0]          xr_reg;
    logic                   last_reg;
    logic                   done_reg;

    logic [COORD_BITS-1:0]  cx;
    logic [COORD_BITS-1:0]  cy;
    logic [OW-1:0]          ox;
    logic [OW-1:0]          oy;
    logic                   rec_done;
    logic [WW-1:0]          cx_w;
    logic [WW-1:0]          cy_w;
    logic [WW-1:0]          ox_w;
    logic [WW-1:0]          oy_w;

    logic                   load;
    logic [WW-1:0]          y_w;
    logic [WW-1:0]          dx_w;
    logic                   span_last;
    logic [WW-1:0]          xl_w;
    logic [WW-1:0]          xr_w;

    assign {cx, cy, ox, oy, rec_done} = rec_reg;
    assign cx_w = {{(WW - COORD_BITS){cx[COORD_BITS-1]}}, cx};
    assign cy_w = {{(WW - COORD_BITS){cy[COORD_BITS-1]}}, cy};
    assign ox_w = {{(WW - OW){ox[OW-1]}}, ox};
    assign oy_w = {{(WW - OW){oy[OW-1]}}, oy};

    assign load = rec_valid_reg && (!out_valid_reg || !out_stall);
    // A new step record is taken when none is held or while the last span of the current one goes out.
    assign pop  = !q_status.empty &&
                  (!rec_valid_reg || (load && (sel_reg == csg_pkg::SEL_3)));

    always_comb
    begin
        sel_next = sel_reg;
        if (pop)
        begin
            sel_next = csg_pkg::SEL_0;
        end
        else if (load)
        begin
            unique case (sel_reg)
                csg_pkg::SEL_0: sel_next = csg_pkg::SEL_1;
                csg_pkg::SEL_1: sel_next = csg_pkg::SEL_2;
                csg_pkg::SEL_2: sel_next = csg_pkg::SEL_3;
                csg_pkg::SEL_3: sel_next = csg_pkg::SEL_0;
                default:        sel_next = csg_pkg::SEL_0;
            endcase
        end
    end

    // Spans are mirrored about the center; only the row offset and half width vary.
    always_comb
    begin
        y_w       = cy_w;
        dx_w      = oy_w;
        span_last = 1'b0;
        unique case (sel_reg)
            csg_pkg::SEL_0:
            begin
                y_w  = cy_w + ox_w;
                dx_w = oy_w;
            end
            csg_pkg::SEL_1:
            begin
                y_w  = cy_w + oy_w;
                dx_w = ox_w;
            end
            csg_pkg::SEL_2:
            begin
                y_w  = cy_w - oy_w;
                dx_w = ox_w;
            end
            csg_pkg::SEL_3:
            begin
                y_w       = cy_w - ox_w;
                dx_w      = oy_w;
                span_last = 1'b1;
            end
            default:
            begin
                y_w  = cy_w;
                dx_w = oy_w;
            end
        endcase
    end

    assign xl_w = cx_w - dx_w;
    assign xr_w = cx_w + dx_w;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rec_valid_reg <= 1'b0;
            sel_reg       <= csg_pkg::SEL_0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sel_reg <= sel_next;
            if (pop)
            begin
                rec_valid_reg <= 1'b1;
            end
            else if (load && (sel_reg == csg_pkg::SEL_3))
            begin
                rec_valid_reg <= 1'b0;
            end
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            rec_reg <= head_data;
        end
        if (load)
        begin
            y_reg    <= y_w[SW-1:0];
            xl_reg   <= xl_w[SW-1:0];
            xr_reg   <= xr_w[SW-1:0];
            last_reg <= span_last;
            done_reg <= span_last && rec_done;
        end
    end

    assign out_valid    = out_valid_reg;
    assign span_y       = y_reg;
    assign span_x_left  = xl_reg;
    assign span_x_right = xr_reg;
    assign last_of_step = last_reg;
    assign circle_done  = done_reg;

endmodule

`default_nettype wire

// ----- rtl/filled_circle_span_generator_top.sv -----
// An accepted advance passes through the step queue, the step record register and
// the output register. Throughput: one span per cycle while out_stall is low, four
// spans per advance step; a two-entry step queue lets up to two further advances
// enter at one per cycle. Start transactions and idle advances produce no span.
// Reset (rst_n low, asynchronous) empties the queue and output stage and leaves
// the block idle with the front end's stored circle and offsets at zero.
`timescale 1ns / 1ps
`default_nettype none

module filled_circle_span_generator_top #(
    parameter int COORD_BITS  = 12,
    parameter int RADIUS_BITS = 10
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic                   mode,
    input  wire logic [COORD_BITS-1:0]  circle_x,
    input  wire logic [COORD_BITS-1:0]  circle_y,
    input  wire logic [RADIUS_BITS-1:0] radius,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic [COORD_BITS:0]         span_y,
    output logic [COORD_BITS:0]         span_x_left,
    output logic [COORD_BITS:0]         span_x_right,
    output logic                        last_of_step,
    output logic                        circle_done
);

    localparam int OW = RADIUS_BITS + 2;
    localparam int RW = 2 * COORD_BITS + 2 * OW + 1;

    csg_pkg::q_status_t q_status;
    logic               push;
    logic [RW-1:0]      push_data;
    logic               pop;
    logic [RW-1:0]      head_data;

    csg_front #(
        .COORD_BITS  (COORD_BITS),
        .RADIUS_BITS (RADIUS_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .mode      (mode),
        .circle_x  (circle_x),
        .circle_y  (circle_y),
        .radius    (radius),
        .q_status  (q_status),
        .push      (push),
        .push_data (push_data)
    );

    csg_queue #(
        .WIDTH (RW),
        .DEPTH (2)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head_data (head_data),
        .status    (q_status)
    );

    csg_back #(
        .COORD_BITS  (COORD_BITS),
        .RADIUS_BITS (RADIUS_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_data    (head_data),
        .q_status     (q_status),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .span_y       (span_y),
        .span_x_left  (span_x_left),
        .span_x_right (span_x_right),
        .last_of_step (last_of_step),
        .circle_done  (circle_done)
    );

endmodule

`default_nettype wire

// ----- rtl/csg_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module csg_checker #(
    parameter int COORD_BITS = 12
) (
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  out_valid,
    input wire logic                  out_stall,
    input wire logic [COORD_BITS:0]   span_y,
    input wire logic [COORD_BITS:0]   span_x_left,
    input wire logic [COORD_BITS:0]   span_x_right,
    input wire logic                  last_of_step,
    input wire logic                  circle_done
);

    // The output stage is empty whenever reset is applied.
    a_reset_empty: assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("span output valid during reset");

    // A finished circle is only flagged on the closing span of a step.
    a_done_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && circle_done |-> last_of_step)
        else $error("circle_done without last_of_step");

    // Spans are symmetric about the center, so left never lies right of right
    // on a step's closing span, which carries the widest half width.
    a_span_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last_of_step && !circle_done |->
            ($signed(span_x_left) <= $signed(span_x_right)))
        else $error("span with left edge past right edge");

    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(span_y) &&
            $stable(span_x_left) && $stable(span_x_right) &&
            $stable(last_of_step) && $stable(circle_done))
        else $error("stalled span changed");

endmodule

bind filled_circle_span_generator_top csg_checker #(
    .COORD_BITS (COORD_BITS)
) u_csg_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .span_y       (span_y),
    .span_x_left  (span_x_left),
    .span_x_right (span_x_right),
    .last_of_step (last_of_step),
    .circle_done  (circle_done)
);

`default_nettype wire

// ----- tb/tb_filled_circle_span_generator_top.sv -----
`timescale 1ns / 1ps

module tb_filled_circle_span_generator_top;

    localparam int COORD_W = 12;
    localparam int RAD_W = 10;
    localparam int SPAN_W = COORD_W + 1;
    localparam int RANDOM_ITEMS = 290;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 20;
    localparam int PRESSURE_HOLD = 150;
    localparam logic MODE_START = 1'b0;
    localparam logic MODE_ADVANCE = 1'b1;

    typedef struct packed {
        logic [SPAN_W-1:0] y;
        logic [SPAN_W-1:0] x_left;
        logic [SPAN_W-1:0] x_right;
        logic              last;
        logic              done;
    } span_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic               mode;
    logic [COORD_W-1:0] circle_x;
    logic [COORD_W-1:0] circle_y;
    logic [RAD_W-1:0]   radius;
    logic               out_valid;
    logic               out_stall;
    logic [SPAN_W-1:0]  span_y;
    logic [SPAN_W-1:0]  span_x_left;
    logic [SPAN_W-1:0]  span_x_right;
    logic               last_of_step;
    logic               circle_done;

    // Rasterizer state as the block should hold it.
    int    ctr_x;
    int    ctr_y;
    int    rad_len;
    int    off_x;
    int    off_y;
    int    decision_acc;
    bit    drawing;
    span_t expected_spans[$];

    int error_count = 0;
    int item_count = 0;
    int quiet_cycles = 0;
    int hold_request = 0;
    bit no_idle = 1'b0;

    filled_circle_span_generator_top #(
        .COORD_BITS  (COORD_W),
        .RADIUS_BITS (RAD_W)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .mode         (mode),
        .circle_x     (circle_x),
        .circle_y     (circle_y),
        .radius       (radius),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .span_y       (span_y),
        .span_x_left  (span_x_left),
        .span_x_right (span_x_right),
        .last_of_step (last_of_step),
        .circle_done  (circle_done)
    );

    initial clk = 1'b0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        else if (roll < 85)
            return $urandom_range(1, 3);
        else if (roll < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic int pick_radius();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return $urandom_range(0, 12);
        else if (roll < 92)
            return $urandom_range(13, 60);
        else
            return $urandom_range(61, 150);
    endfunction

    function automatic span_t make_span(int y, int xl, int xr, logic last, logic done);
        span_t s;
        s.y = y[SPAN_W-1:0];
        s.x_left = xl[SPAN_W-1:0];
        s.x_right = xr[SPAN_W-1:0];
        s.last = last;
        s.done = done;
        return s;
    endfunction

    // Applies one accepted transaction and queues the spans it should produce.
    task automatic rasterize(input logic m, input logic [COORD_W-1:0] cx,
                             input logic [COORD_W-1:0] cy, input logic [RAD_W-1:0] r);
        int   ox;
        int   oy;
        logic finished;
        if (m == MODE_START)
        begin
            ctr_x = $signed(cx);
            ctr_y = $signed(cy);
            rad_len = r;
            off_x = 0;
            off_y = rad_len;
            decision_acc = rad_len - 1;
            drawing = 1'b1;
        end
        else if (drawing)
        begin
            ox = off_x;
            oy = off_y;
            if (decision_acc >= 2 * ox)
            begin
                decision_acc -= 2 * ox + 1;
                off_x = ox + 1;
            end
            else if (decision_acc < 2 * (rad_len - oy))
            begin
                decision_acc += 2 * oy - 1;
                off_y = oy - 1;
            end
            else
            begin
                decision_acc += 2 * (oy - ox - 1);
                off_y = oy - 1;
                off_x = ox + 1;
            end
            finished = off_y < off_x;
            if (finished)
                drawing = 1'b0;
            expected_spans.push_back(make_span(ctr_y + ox, ctr_x - oy, ctr_x + oy, 1'b0, 1'b0));
            expected_spans.push_back(make_span(ctr_y + oy, ctr_x - ox, ctr_x + ox, 1'b0, 1'b0));
            expected_spans.push_back(make_span(ctr_y - oy, ctr_x - ox, ctr_x + ox, 1'b0, 1'b0));
            expected_spans.push_back(make_span(ctr_y - ox, ctr_x - oy, ctr_x + oy, 1'b1,
                                               finished));
        end
    endtask

    // Valid stays high after a transaction so that a back-to-back item needs no
    // second assignment in the same time step; callers that wait lower it first.
    task automatic send_item(input logic m, input logic [COORD_W-1:0] cx,
                             input logic [COORD_W-1:0] cy, input logic [RAD_W-1:0] r);
        int gap;
        gap = no_idle ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        mode <= m;
        circle_x <= cx;
        circle_y <= cy;
        radius <= r;
        do @(posedge clk); while (in_stall);
        if (m == MODE_START || drawing)
            item_count++;
        rasterize(m, cx, cy, r);
    endtask

    task automatic start_circle(input int cx, input int cy, input int r);
        send_item(MODE_START, cx[COORD_W-1:0], cy[COORD_W-1:0], r[RAD_W-1:0]);
    endtask

    // The coordinate fields are ignored on an advance, so they carry noise.
    task automatic advance();
        logic [COORD_W-1:0] nx;
        logic [COORD_W-1:0] ny;
        logic [RAD_W-1:0]   nr;
        nx = COORD_W'($urandom);
        ny = COORD_W'($urandom);
        nr = RAD_W'($urandom);
        send_item(MODE_ADVANCE, nx, ny, nr);
    endtask

    task automatic finish_circle();
        while (drawing)
            advance();
    endtask

    task automatic test_advance_while_idle();
        repeat (3) advance();
    endtask

    task automatic test_zero_radius();
        start_circle(0, 0, 0);
        advance();
        advance();
        start_circle(-1, 1, 0);
        advance();
    endtask

    task automatic test_extreme_centers();
        start_circle(-2048, -2048, 1023);
        repeat (3) advance();
        start_circle(2047, 2047, 1023);
        repeat (3) advance();
        start_circle(-2048, 2047, 1);
        finish_circle();
    endtask

    task automatic test_restart_mid_circle();
        start_circle(100, -50, 20);
        repeat (2) advance();
        start_circle(2047, -2048, 3);
        finish_circle();
        advance();
    endtask

    // The receiver holds off while advances keep coming, so the step queue
    // fills and the block has to stall its input.
    task automatic test_backpressure();
        in_valid <= 1'b0;
        hold_request = PRESSURE_HOLD;
        do @(posedge clk); while (hold_request != 0);
        no_idle = 1'b1;
        start_circle($urandom, $urandom, 60);
        repeat (20) advance();
        no_idle = 1'b0;
    endtask

    task automatic test_random_circles();
        int base;
        int roll;
        base = item_count;
        while (item_count - base < RANDOM_ITEMS)
        begin
            no_idle = (item_count - base >= 150) && (item_count - base < 200);
            roll = $urandom_range(0, 99);
            if (roll < 80)
            begin
                start_circle($urandom, $urandom, pick_radius());
                finish_circle();
                if ($urandom_range(0, 3) == 0)
                    advance();
            end
            else if (roll < 92)
            begin
                // Abandoned circle: any radius, cut short by the next start.
                start_circle($urandom, $urandom, $urandom);
                repeat ($urandom_range(0, 6)) advance();
            end
            else
            begin
                repeat ($urandom_range(1, 3)) advance();
            end
        end
        no_idle = 1'b0;
    endtask

    initial
    begin : receiver_stall
        int   len;
        logic level;
        forever
        begin
            if (hold_request > 0)
            begin
                level = 1'b1;
                len = hold_request;
                hold_request = 0;
            end
            else if (no_idle)
            begin
                level = 1'b0;
                len = 1;
            end
            else
            begin
                level = ($urandom_range(0, 2) == 0);
                len = pick_gap() + 1;
            end
            out_stall <= level;
            repeat (len) @(posedge clk);
        end
    end

    function automatic void check_field(input string name, input logic [SPAN_W-1:0] want,
                                        input logic [SPAN_W-1:0] got);
        if (got !== want)
        begin
            error_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name,
                     $signed(want), $signed(got));
        end
    endfunction

    always @(posedge clk)
    begin
        span_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_spans.size() == 0)
            begin
                error_count++;
                $display("%0t: span with none expected, actual y=%0d x=%0d..%0d", $time,
                         $signed(span_y), $signed(span_x_left), $signed(span_x_right));
            end
            else
            begin
                want = expected_spans.pop_front();
                check_field("span_y", want.y, span_y);
                check_field("span_x_left", want.x_left, span_x_left);
                check_field("span_x_right", want.x_right, span_x_right);
                check_field("last_of_step", SPAN_W'(want.last), SPAN_W'(last_of_step));
                check_field("circle_done", SPAN_W'(want.done), SPAN_W'(circle_done));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    initial
    begin
        in_valid <= 1'b0;
        mode <= MODE_START;
        circle_x <= '0;
        circle_y <= '0;
        radius <= '0;
        rst_n <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        test_advance_while_idle();
        test_zero_radius();
        test_extreme_centers();
        test_restart_mid_circle();
        test_backpressure();
        test_random_circles();

        in_valid <= 1'b0;
        while (expected_spans.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
